[rtl/lmsc_pkg.sv]
package lmsc_pkg;

    localparam int ROWS_DEFAULT          = 6;
    localparam int PRESCALE_BITS_DEFAULT = 8;
    localparam int ROW_BITS              = 24;

    localparam logic [7:0] THRESHOLD_RESET = 8'd50;

    // Command bytes recognised while not loading.
    localparam logic [7:0] CMD_LOAD   = 8'h49;  // 'I'
    localparam logic [7:0] CMD_STEP   = 8'h53;  // 'S'
    localparam logic [7:0] CMD_STOP   = 8'h42;  // 'B'
    localparam logic [7:0] CMD_RESUME = 8'h43;  // 'C'

    typedef enum logic {
        ITEM_BYTE = 1'b0,
        ITEM_TICK = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t  cmd;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]          row_index;
        logic [ROW_BITS-1:0] row_bits;
        logic                last_row;
    } out_item_t;

    typedef enum logic [1:0] {
        STORE_NONE,
        STORE_BYTE,
        STORE_ROTATE
    } store_op_t;

    // Byte lane k covers row bits 8k+7 down to 8k.
    typedef struct packed {
        store_op_t   op;
        logic [1:0]  lane;
        logic [7:0]  data;
    } store_ctrl_t;

    // Power-on frame pattern, repeating every six rows.
    function automatic logic [ROW_BITS-1:0] reset_row(input int phase);
        logic [ROW_BITS-1:0] value;
        unique case (phase)
            0, 5:    value = 24'h111111;
            1, 4:    value = 24'h222222;
            default: value = 24'h444444;
        endcase
        return value;
    endfunction

endpackage

[rtl/lmsc_frame_store.sv]
module lmsc_frame_store #(
    parameter int ROWS  = lmsc_pkg::ROWS_DEFAULT,
    parameter int IDX_W = 3
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lmsc_pkg::store_ctrl_t         ctrl,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic [IDX_W-1:0]              rd_addr,
    output logic [lmsc_pkg::ROW_BITS-1:0] rd_row
);
    import lmsc_pkg::*;

    logic [ROW_BITS-1:0] frame_reg [ROWS];

    // The shared row unit: one byte-lane write or one left rotation per cycle.
    for (genvar g = 0; g < ROWS; g++) begin : g_row
        localparam int Phase = g % 6;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                frame_reg[g] <= reset_row(Phase);
            end else if (wr_addr == IDX_W'(g)) begin
                unique case (ctrl.op)
                    STORE_BYTE: begin
                        unique case (ctrl.lane)
                            2'd0:    frame_reg[g][7:0]   <= ctrl.data;
                            2'd1:    frame_reg[g][15:8]  <= ctrl.data;
                            2'd2:    frame_reg[g][23:16] <= ctrl.data;
                            default: frame_reg[g]        <= frame_reg[g];
                        endcase
                    end
                    STORE_ROTATE: begin
                        frame_reg[g] <= {frame_reg[g][ROW_BITS-2:0],
                                         frame_reg[g][ROW_BITS-1]};
                    end
                    default: frame_reg[g] <= frame_reg[g];
                endcase
            end
        end
    end

    assign rd_row = frame_reg[rd_addr];

endmodule

[rtl/led_matrix_scroll_controller_top.sv]
// A plain received byte is handled without leaving the idle state, so the block stays ready for the next item.
// An 'S' byte holds the input off while the row unit rotates each row in turn.
// A refresh tick is accepted while idle; rows then leave the output register one per cycle
// when the consumer keeps up, with the input held off until the last row is registered.
// Reset is synchronous and active low: it restores the power-on frame and a threshold of 50.
module led_matrix_scroll_controller_top #(
    parameter int ROWS          = lmsc_pkg::ROWS_DEFAULT,
    parameter int PRESCALE_BITS = lmsc_pkg::PRESCALE_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lmsc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lmsc_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_wdata
);
    import lmsc_pkg::*;

    // Row pointer width, and a load counter that can also hold ROWS itself.
    localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W = $clog2(ROWS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_SPIN
    } state_t;

    state_t                   state_reg;
    logic [IDX_W-1:0]         ptr_reg;
    logic                     rot_flag_reg;
    logic                     loading_reg;
    logic [CNT_W-1:0]         load_row_reg;
    logic [1:0]               load_sub_reg;
    logic                     scroll_en_reg;
    logic [PRESCALE_BITS-1:0] prescale_reg;
    logic [7:0]               scroll_cnt_reg;
    logic [7:0]               threshold_reg;
    logic                     m_valid_reg;
    out_item_t                m_data_reg;

    logic                     in_fire;
    logic                     out_free;
    logic                     last_ptr;
    logic                     load_done;
    logic [PRESCALE_BITS-1:0] prescale_next;
    logic [7:0]               scroll_bumped;
    logic                     auto_rotate;
    logic [7:0]               scroll_next;
    store_ctrl_t              store_ctrl;
    logic [IDX_W-1:0]         store_wr_addr;
    logic [ROW_BITS-1:0]      store_rd_row;

    // The block takes a new item only between operations; the output register
    // lets it do so while the final row of a pass still waits to be taken.
    assign s_ready   = (state_reg == S_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign last_ptr  = (ptr_reg == IDX_W'(ROWS - 1));
    assign load_done = (load_row_reg == CNT_W'(ROWS));

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Prescaler and scroll counter update for a tick. The decision to rotate
    // does not depend on the frame, so it is made when the tick is accepted and
    // the rotation is applied to each row just after that row has been shown.
    always_comb begin
        prescale_next = prescale_reg + 1'b1;
        if ((prescale_next == '0) && scroll_en_reg) begin
            scroll_bumped = scroll_cnt_reg + 8'd1;
        end else begin
            scroll_bumped = scroll_cnt_reg;
        end
        auto_rotate = scroll_en_reg && (scroll_bumped > threshold_reg);
        scroll_next = auto_rotate ? 8'd1 : scroll_bumped;
    end

    // Drive the shared row unit: a frame byte during a load, otherwise a
    // rotation of the row under the pointer when a sweep calls for one.
    always_comb begin
        store_ctrl    = '{op: STORE_NONE, lane: 2'd0, data: s_data.rx_byte};
        store_wr_addr = ptr_reg;
        unique case (state_reg)
            S_IDLE: begin
                store_wr_addr = load_row_reg[IDX_W-1:0];
                if (in_fire && (s_data.cmd == ITEM_BYTE) && loading_reg && !load_done) begin
                    store_ctrl.op   = STORE_BYTE;
                    store_ctrl.lane = 2'd2 - load_sub_reg;
                end
            end
            S_EMIT: begin
                if (out_free && rot_flag_reg) begin
                    store_ctrl.op = STORE_ROTATE;
                end
            end
            S_SPIN: begin
                store_ctrl.op = STORE_ROTATE;
            end
            default: begin
                store_ctrl.op = STORE_NONE;
            end
        endcase
    end

    lmsc_frame_store #(
        .ROWS  (ROWS),
        .IDX_W (IDX_W)
    ) u_frame_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (store_ctrl),
        .wr_addr (store_wr_addr),
        .rd_addr (ptr_reg),
        .rd_row  (store_rd_row)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ptr_reg        <= '0;
            rot_flag_reg   <= 1'b0;
            loading_reg    <= 1'b0;
            load_row_reg   <= '0;
            load_sub_reg   <= 2'd0;
            scroll_en_reg  <= 1'b1;
            prescale_reg   <= '0;
            scroll_cnt_reg <= 8'd0;
            threshold_reg  <= THRESHOLD_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                threshold_reg <= cfg_wdata;
            end

            // During a sweep the output register is refilled in the emit branch
            // whenever its row is taken, so it is only emptied here otherwise.
            if (m_valid_reg && m_ready && (state_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire && (s_data.cmd == ITEM_TICK)) begin
                        prescale_reg   <= prescale_next;
                        scroll_cnt_reg <= scroll_next;
                        rot_flag_reg   <= auto_rotate;
                        ptr_reg        <= '0;
                        state_reg      <= S_EMIT;
                    end else if (in_fire && loading_reg) begin
                        if (load_done) begin
                            // The byte after a full frame is swallowed.
                            loading_reg <= 1'b0;
                        end else if (load_sub_reg == 2'd2) begin
                            load_sub_reg <= 2'd0;
                            load_row_reg <= load_row_reg + 1'b1;
                        end else begin
                            load_sub_reg <= load_sub_reg + 2'd1;
                        end
                    end else if (in_fire) begin
                        priority if (s_data.rx_byte == CMD_LOAD) begin
                            loading_reg  <= 1'b1;
                            load_row_reg <= '0;
                            load_sub_reg <= 2'd0;
                        end else if (s_data.rx_byte == CMD_STEP) begin
                            ptr_reg   <= '0;
                            state_reg <= S_SPIN;
                        end else if (s_data.rx_byte == CMD_STOP) begin
                            scroll_en_reg <= 1'b0;
                        end else if (s_data.rx_byte == CMD_RESUME) begin
                            scroll_en_reg <= 1'b1;
                        end else begin
                            // Unknown bytes are ignored.
                            scroll_en_reg <= scroll_en_reg;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg          <= 1'b1;
                        m_data_reg.row_index <= 3'(ptr_reg);
                        m_data_reg.row_bits  <= store_rd_row;
                        m_data_reg.last_row  <= last_ptr;
                        if (last_ptr) begin
                            ptr_reg   <= '0;
                            state_reg <= S_IDLE;
                        end else begin
                            ptr_reg <= ptr_reg + 1'b1;
                        end
                    end
                end
                S_SPIN: begin
                    if (last_ptr) begin
                        ptr_reg   <= '0;
                        state_reg <= S_IDLE;
                    end else begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The load position never runs past the end of the frame.
    a_load_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        load_row_reg <= CNT_W'(ROWS))
        else $error("load row counter past end of frame");

    // The row pointer stays within the frame during a sweep.
    a_ptr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (ptr_reg <= IDX_W'(ROWS - 1)))
        else $error("row pointer outside frame");

    // A stalled output register holds the sweep at its current row.
    a_emit_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && m_valid_reg && !m_ready) |=>
            ($stable(ptr_reg) && state_reg == S_EMIT))
        else $error("row sweep advanced while output stalled");

    // An accepted refresh tick always starts a pass from the first row.
    a_tick_starts_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_data.cmd == ITEM_TICK) |=> (state_reg == S_EMIT && ptr_reg == '0))
        else $error("refresh tick did not start a row pass");

endmodule

[sim/led_matrix_scroll_controller_top_tb.sv]
`timescale 1ns / 1ps

module led_matrix_scroll_controller_top_tb;

    import lmsc_pkg::*;

    localparam int ROWS          = ROWS_DEFAULT;
    localparam int PRESCALE_BITS = PRESCALE_BITS_DEFAULT;
    localparam int LOAD_BYTES    = 3 * ROWS;
    // This margin covers any work still in flight (a byte, an 'S' rotation pass or a tick's
    // row pass) once the last expected row has arrived.
    localparam int QUIET_CYCLES  = 2 * ROWS + 4;
    // The receiver's long hold-off, in clock cycles.
    localparam int HOLD_CYCLES   = 400;

    // Clock, reset and the ports of the block. Every input starts at a known value.
    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_item_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_item_t m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [7:0] cfg_wdata = '0;

    // Shared control between the sending side and the receiving process.
    bit no_idle  = 1'b0;    // when set, neither side inserts idle cycles
    bit hold_req = 1'b0;    // asks the receiver for one long hold-off
    int mismatch_count = 0;

    // Rows that the block is expected to emit, oldest first.
    out_item_t pending_rows [$];

    // Predicted state of the display controller.
    logic [ROW_BITS-1:0]      frame [ROWS];
    bit                       loading;
    int                       loaded_bytes;
    bit                       scroll_on;
    logic [PRESCALE_BITS-1:0] prescale;
    logic [7:0]               scroll_steps;
    logic [7:0]               scroll_limit;

    logic [7:0] directed_frame [18];

    led_matrix_scroll_controller_top #(
        .ROWS          (ROWS),
        .PRESCALE_BITS (PRESCALE_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Power-on state: the diamond pattern repeats every six rows.
    function automatic void reset_frame_state();
        for (int r = 0; r < ROWS; r++) begin
            case (r % 6)
                0, 5:    frame[r] = 24'h111111;
                1, 4:    frame[r] = 24'h222222;
                default: frame[r] = 24'h444444;
            endcase
        end
        loading      = 1'b0;
        loaded_bytes = 0;
        scroll_on    = 1'b1;
        prescale     = '0;
        scroll_steps = '0;
        scroll_limit = THRESHOLD_RESET;
    endfunction

    // Rotates every row left by one column; the top column wraps round to column 0.
    function automatic void rotate_frame();
        for (int r = 0; r < ROWS; r++) begin
            frame[r] = {frame[r][ROW_BITS-2:0], frame[r][ROW_BITS-1]};
        end
    endfunction

    // Applies one accepted input transfer to the predicted state and queues the rows
    // that a refresh tick is bound to produce.
    function automatic void apply_item(input in_item_t item);
        out_item_t row;
        if (item.cmd == ITEM_BYTE) begin
            if (!loading) begin
                case (item.rx_byte)
                    CMD_LOAD: begin
                        loading      = 1'b1;
                        loaded_bytes = 0;
                    end
                    CMD_STEP:   rotate_frame();
                    CMD_STOP:   scroll_on = 1'b0;
                    CMD_RESUME: scroll_on = 1'b1;
                    default: ;
                endcase
            end else if (loaded_bytes < LOAD_BYTES) begin
                // Row-major, the first byte of each row landing in the top lane.
                frame[loaded_bytes / 3][8 * (2 - loaded_bytes % 3) +: 8] = item.rx_byte;
                loaded_bytes++;
            end else begin
                // The byte after a full load is swallowed and ends the load.
                loading = 1'b0;
            end
        end else begin
            for (int r = 0; r < ROWS; r++) begin
                row.row_index = r[2:0];
                row.row_bits  = frame[r];
                row.last_row  = (r == ROWS - 1);
                pending_rows.push_back(row);
            end
            prescale = prescale + 1'b1;
            if (prescale == '0 && scroll_on) begin
                scroll_steps = scroll_steps + 8'd1;
            end
            // The comparison runs on every tick, not only on a prescaler wrap.
            if (scroll_steps > scroll_limit && scroll_on) begin
                scroll_steps = 8'd1;
                rotate_frame();
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking: one process takes every row transfer and compares it
    // with the oldest expectation.
    // ------------------------------------------------------------------

    function automatic void check_row(input out_item_t actual);
        out_item_t expected;
        if (pending_rows.size() == 0) begin
            $error("unexpected row transfer: row_index %0d, row_bits %06h, last_row %0b",
                   actual.row_index, actual.row_bits, actual.last_row);
            mismatch_count++;
            return;
        end
        expected = pending_rows.pop_front();
        if (actual.row_index !== expected.row_index) begin
            $error("row_index: expected %0d, actual %0d", expected.row_index, actual.row_index);
            mismatch_count++;
        end
        if (actual.row_bits !== expected.row_bits) begin
            $error("row_bits: expected %06h, actual %06h", expected.row_bits, actual.row_bits);
            mismatch_count++;
        end
        if (actual.last_row !== expected.last_row) begin
            $error("last_row: expected %0b, actual %0b", expected.last_row, actual.last_row);
            mismatch_count++;
        end
    endfunction

    // The receiver draws a stall before every row. A requested hold-off replaces one
    // such stall, so ready is only ever assigned once in a time step.
    initial begin : row_receiver
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 16);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            check_row(m_data);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one item after a random gap and returns at the edge of its transfer.
    // Valid is only lowered when a gap follows, so back-to-back items keep it high.
    task automatic send_item(input item_kind_t kind, input logic [7:0] value);
        int       gap;
        in_item_t item;
        gap          = no_idle ? 0 : $urandom_range(0, 16);
        item.cmd     = kind;
        item.rx_byte = value;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        apply_item(item);
    endtask

    task automatic send_tick();
        send_item(ITEM_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_tick();
    endtask

    // Withdraws the input, waits for every expected row and lets the block settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // Writes the scroll threshold; only called once the block has gone idle.
    task automatic write_threshold(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        scroll_limit = value;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One refresh pass straight after reset shows the power-on frame.
    task automatic test_power_on_frame();
        send_tick();
    endtask

    // A full load with extreme and command-like data bytes, then the swallowed byte.
    // An 'S' is used as that byte: were it not swallowed, the next pass would be rotated.
    task automatic test_frame_load();
        directed_frame = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE,
                           8'hAA, 8'h55, 8'h49, 8'h53, 8'h42, 8'h43,
                           8'h11, 8'h22, 8'h44, 8'hC3, 8'h3C, 8'hF0};
        send_item(ITEM_BYTE, CMD_LOAD);
        for (int i = 0; i < LOAD_BYTES; i++) begin
            send_item(ITEM_BYTE, directed_frame[i % 18]);
        end
        send_item(ITEM_BYTE, CMD_STEP);
        send_tick();
    endtask

    // Manual step, stop and resume, and an unknown byte that must be ignored.
    task automatic test_commands();
        send_item(ITEM_BYTE, CMD_STEP);
        send_item(ITEM_BYTE, CMD_STOP);
        send_item(ITEM_BYTE, CMD_RESUME);
        send_item(ITEM_BYTE, 8'hFF);
        send_tick();
    endtask

    // The receiver holds off for a long stretch while ticks keep coming, so the block
    // fills and stalls its input; then the sender waits for every row to drain.
    task automatic test_backpressure();
        wait_idle();
        hold_req = 1'b1;
        no_idle  = 1'b1;
        send_ticks(6);
        no_idle  = 1'b0;
        s_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge aclk);
        send_ticks(2);
    endtask

    // The scroll counter only moves on a prescaler wrap, so ticks run until the
    // prescaler comes round. Under threshold 255 the wrap counts without scrolling;
    // lowering the threshold to 0 then scrolls on the very next tick with no wrap,
    // and on every tick after it. While stopped, ticks do not scroll.
    task automatic test_auto_scroll();
        wait_idle();
        write_threshold(8'd255);
        do send_tick(); while (prescale != '0);
        wait_idle();
        write_threshold(8'd0);
        send_ticks(3);
        send_item(ITEM_BYTE, CMD_STOP);
        send_ticks(2);
        send_item(ITEM_BYTE, CMD_RESUME);
        send_ticks(2);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        reset_frame_state();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_power_on_frame();
        test_frame_load();
        test_commands();
        test_backpressure();
        test_auto_scroll();

        wait_idle();
        if (mismatch_count == 0 && pending_rows.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: the limit here lies far beyond the slowest correct run.
    initial begin
        #(64'd5_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[led_matrix_scroll_controller_top.f]
rtl/lmsc_pkg.sv
rtl/lmsc_frame_store.sv
rtl/led_matrix_scroll_controller_top.sv
sim/led_matrix_scroll_controller_top_tb.sv
